FILE: hdl/dhfk_pkg.sv
// Shared types, constants and tables for the six-joint forward kinematics pipeline.
// No dependencies; the CORDIC, joint and top-level files import this package.
`timescale 1ns / 1ps

package dhfk_pkg;

  localparam int JOINT_COUNT  = 6;
  localparam int CORDIC_STEPS = 30;
  // Stage 0 reduces the angle, 15 stages of two steps each, one stage unfolds the quadrant
  localparam int CORDIC_LAT   = 17;
  localparam int QBITS        = 30;

  typedef logic signed [32:0] rq_t;    // rotation entry, Q30
  typedef logic signed [31:0] trig_t;  // clamped sine or cosine, Q30
  typedef logic signed [32:0] czv_t;   // CORDIC x, y and residual angle
  typedef logic signed [18:0] tloc_t;  // local translation, 2^-16 m
  typedef logic signed [17:0] len_t;   // link length or offset, 2^-16 m
  typedef logic signed [23:0] pos_t;   // running translation, 2^-16 m

  localparam czv_t CORDIC_K = 33'sd652032874;
  localparam rq_t  ONE_Q    = 33'sd1073741824;

  // Arctangent of 2^-i in units of 2^-32 turn
  localparam logic [29:0] ATAN_TURN [CORDIC_STEPS] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722,
    30'd20861, 30'd10430, 30'd5215, 30'd2608, 30'd1304,
    30'd652, 30'd326, 30'd163, 30'd81, 30'd41,
    30'd20, 30'd10, 30'd5, 30'd3, 30'd1
  };

  typedef enum logic [1:0] {
    TWIST_ZERO,
    TWIST_POS,
    TWIST_NEG
  } dhfk_twist_e;

  localparam dhfk_twist_e JOINT_TWIST [JOINT_COUNT] = '{
    TWIST_POS, TWIST_ZERO, TWIST_ZERO, TWIST_POS, TWIST_NEG, TWIST_ZERO
  };

  typedef enum logic [2:0] {
    REG_D1 = 3'd0,
    REG_A2 = 3'd1,
    REG_A3 = 3'd2,
    REG_D4 = 3'd3,
    REG_D5 = 3'd4,
    REG_D6 = 3'd5
  } dhfk_reg_e;

  localparam len_t RST_D1 = 18'sd5843;
  localparam len_t RST_A2 = -18'sd27853;
  localparam len_t RST_A3 = -18'sd25706;
  localparam len_t RST_D4 = 18'sd7153;
  localparam len_t RST_D5 = 18'sd6203;
  localparam len_t RST_D6 = 18'sd5394;

  // Per-joint trig values and local translations that ride along the chain
  typedef struct packed {
    logic [JOINT_COUNT-1:0][31:0] c;
    logic [JOINT_COUNT-1:0][31:0] s;
    logic [JOINT_COUNT-1:0][18:0] t0;
    logic [JOINT_COUNT-1:0][18:0] t1;
  } dhfk_side_t;

endpackage

FILE: hdl/dhfk_if.sv
// Valid/ready channel interfaces: joint angle words, pose words, register writes.
// No dependencies.
`timescale 1ns / 1ps

interface dhfk_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] angle_j1;
  logic [15:0] angle_j2;
  logic [15:0] angle_j3;
  logic [15:0] angle_j4;
  logic [15:0] angle_j5;
  logic [15:0] angle_j6;
  modport source (output valid, angle_j1, angle_j2, angle_j3, angle_j4, angle_j5,
                  angle_j6, input ready);
  modport sink (input valid, angle_j1, angle_j2, angle_j3, angle_j4, angle_j5,
                angle_j6, output ready);
endinterface

interface dhfk_out_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] rot_00;
  logic signed [17:0] rot_01;
  logic signed [17:0] rot_02;
  logic signed [17:0] rot_10;
  logic signed [17:0] rot_11;
  logic signed [17:0] rot_12;
  logic signed [17:0] rot_20;
  logic signed [17:0] rot_21;
  logic signed [17:0] rot_22;
  logic signed [19:0] pos_x;
  logic signed [19:0] pos_y;
  logic signed [19:0] pos_z;
  modport source (output valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
                  rot_20, rot_21, rot_22, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
                rot_20, rot_21, rot_22, pos_x, pos_y, pos_z, output ready);
endinterface

interface dhfk_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [17:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/dhfk_cordic.sv
// Pipelined CORDIC: cosine and sine in Q30 of one joint angle, two steps per stage.
// Depends on dhfk_pkg (arctangent table, gain, types).
`timescale 1ns / 1ps

module dhfk_cordic import dhfk_pkg::*; #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic [CORDIC_LAT-1:0] en_i,
  input  logic [15:0]           angle_i,
  output trig_t                 cos_o,
  output trig_t                 sin_o
);

  localparam int NSTG = CORDIC_STEPS / 2;

  logic [47:0] ang_wide;
  logic [31:0] turn;
  logic [31:0] turn_rnd;
  logic [31:0] resid;
  logic [1:0]  quad;

  czv_t       x_q [NSTG+1];
  czv_t       y_q [NSTG+1];
  czv_t       z_q [NSTG+1];
  logic [1:0] q_q [NSTG+1];

  function automatic trig_t clamp_q(czv_t v);
    czv_t lim;
    lim = czv_t'(ONE_Q);
    if (v > lim) begin
      return trig_t'(lim);
    end else if (v < -lim) begin
      return trig_t'(-lim);
    end
    return trig_t'(v);
  endfunction

  // Scale to a 32-bit turn, split off the nearest quadrant
  always_comb begin
    ang_wide = {32'd0, angle_i} << (32 - ANGLE_BITS);
    turn     = ang_wide[31:0];
    turn_rnd = turn + 32'h2000_0000;
    quad     = turn_rnd[31:30];
    resid    = turn - {quad, 30'd0};
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      x_q[0] <= CORDIC_K;
      y_q[0] <= '0;
      z_q[0] <= {resid[31], resid};
      q_q[0] <= quad;
    end
  end

  // Rotation steps, two per stage
  for (genvar g = 0; g < NSTG; g++) begin : g_step
    localparam int S0 = 2 * g;
    localparam int S1 = 2 * g + 1;
    czv_t xa, ya, za, xb, yb, zb;

    always_comb begin
      if (!z_q[g][32]) begin
        xa = x_q[g] - (y_q[g] >>> S0);
        ya = y_q[g] + (x_q[g] >>> S0);
        za = z_q[g] - $signed({3'b000, ATAN_TURN[S0]});
      end else begin
        xa = x_q[g] + (y_q[g] >>> S0);
        ya = y_q[g] - (x_q[g] >>> S0);
        za = z_q[g] + $signed({3'b000, ATAN_TURN[S0]});
      end
      if (!za[32]) begin
        xb = xa - (ya >>> S1);
        yb = ya + (xa >>> S1);
        zb = za - $signed({3'b000, ATAN_TURN[S1]});
      end else begin
        xb = xa + (ya >>> S1);
        yb = ya - (xa >>> S1);
        zb = za + $signed({3'b000, ATAN_TURN[S1]});
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[g+1]) begin
        x_q[g+1] <= xb;
        y_q[g+1] <= yb;
        z_q[g+1] <= zb;
        q_q[g+1] <= q_q[g];
      end
    end
  end

  // Rotate back by the quadrant and clamp
  czv_t c_w, s_w;
  always_comb begin
    case (q_q[NSTG])
      2'd0: begin
        c_w = x_q[NSTG];
        s_w = y_q[NSTG];
      end
      2'd1: begin
        c_w = -y_q[NSTG];
        s_w = x_q[NSTG];
      end
      2'd2: begin
        c_w = -x_q[NSTG];
        s_w = -y_q[NSTG];
      end
      default: begin
        c_w = y_q[NSTG];
        s_w = -x_q[NSTG];
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[CORDIC_LAT-1]) begin
      cos_o <= clamp_q(c_w);
      sin_o <= clamp_q(s_w);
    end
  end

endmodule

FILE: hdl/dhfk_joint.sv
// One joint of the chain: products in the first stage, rounded sums in the second.
// Depends on dhfk_pkg (types, twist codes).
`timescale 1ns / 1ps

module dhfk_joint import dhfk_pkg::*; (
  input  logic        clk_i,
  input  logic [1:0]  en_i,
  input  dhfk_twist_e twist_i,
  input  rq_t         r_i [3][3],
  input  pos_t        p_i [3],
  input  trig_t       cos_i,
  input  trig_t       sin_i,
  input  tloc_t       t0_i,
  input  tloc_t       t1_i,
  input  len_t        d_i,
  output rq_t         r_o [3][3],
  output pos_t        p_o [3]
);

  logic signed [64:0] r0c_q [3];
  logic signed [64:0] r1s_q [3];
  logic signed [64:0] r0s_q [3];
  logic signed [64:0] r1c_q [3];
  logic signed [51:0] pt0_q [3];
  logic signed [51:0] pt1_q [3];
  logic signed [50:0] pd_q  [3];
  rq_t                r2_q  [3];
  pos_t               p_q   [3];

  // Multiply each row by the joint's cosine, sine and local translation
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int r = 0; r < 3; r++) begin
        r0c_q[r] <= r_i[r][0] * cos_i;
        r1s_q[r] <= r_i[r][1] * sin_i;
        r0s_q[r] <= r_i[r][0] * sin_i;
        r1c_q[r] <= r_i[r][1] * cos_i;
        pt0_q[r] <= r_i[r][0] * t0_i;
        pt1_q[r] <= r_i[r][1] * t1_i;
        pd_q[r]  <= r_i[r][2] * d_i;
        r2_q[r]  <= r_i[r][2];
        p_q[r]   <= p_i[r];
      end
    end
  end

  // Round the sums to Q30 and place columns by twist
  logic signed [65:0] su [3];
  logic signed [65:0] sv [3];
  logic signed [65:0] sw [3];
  logic signed [53:0] sp [3];
  rq_t                n0 [3];
  rq_t                n1 [3];
  rq_t                n2 [3];
  rq_t                nv [3];
  rq_t                nw [3];
  pos_t               dp [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      su[r] = r0c_q[r] + r1s_q[r] + (66'sd1 <<< (QBITS - 1));
      sv[r] = r1c_q[r] - r0s_q[r] + (66'sd1 <<< (QBITS - 1));
      sw[r] = r0s_q[r] - r1c_q[r] + (66'sd1 <<< (QBITS - 1));
      sp[r] = pt0_q[r] + pt1_q[r] + pd_q[r] + (54'sd1 <<< (QBITS - 1));
      n0[r] = rq_t'(su[r] >>> QBITS);
      nv[r] = rq_t'(sv[r] >>> QBITS);
      nw[r] = rq_t'(sw[r] >>> QBITS);
      dp[r] = pos_t'(sp[r] >>> QBITS);
      case (twist_i)
        TWIST_POS: begin
          n1[r] = r2_q[r];
          n2[r] = nw[r];
        end
        TWIST_NEG: begin
          n1[r] = -r2_q[r];
          n2[r] = nv[r];
        end
        default: begin
          n1[r] = nv[r];
          n2[r] = r2_q[r];
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      for (int r = 0; r < 3; r++) begin
        r_o[r][0] <= n0[r];
        r_o[r][1] <= n1[r];
        r_o[r][2] <= n2[r];
        p_o[r]    <= p_q[r] + dp[r];
      end
    end
  end

endmodule

FILE: hdl/dh_forward_kinematics_6dof.sv
// Top level of the six-joint forward kinematics pipeline.
// Depends on dhfk_pkg, dhfk_if, dhfk_cordic and dhfk_joint.
//
// Usage:
//   in_i carries one word of six joint angles; out_o returns one pose word per
//   angle word (3x3 rotation in Q1.FRAC_BITS, translation in 2^-16 m), in order.
//   cfg_i writes the link lengths and offsets (index 0..5); other indexes are
//   dropped. cfg_i is always ready; write it only while the pipeline is empty.
//   A word passes the six parallel CORDIC units, the stage forming the local
//   translations, each joint's stages for the chained matrix products, and
//   the output rounding and saturation stage. Throughput is one word per
//   cycle while the pipeline is not backed up. Every stage holds a valid bit and
//   advances whenever it or any stage after it is empty, so bubbles collapse
//   and input is taken while a finished pose waits at the output. A stalled
//   receiver backs the pipeline up only once every stage is full.
//   Reset empties the pipeline and restores the default link geometry.
`timescale 1ns / 1ps

module dh_forward_kinematics_6dof import dhfk_pkg::*; #(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dhfk_in_if.sink    in_i,
  dhfk_out_if.source out_o,
  dhfk_cfg_if.sink   cfg_i
);

  localparam int SIDE_STG = CORDIC_LAT;
  localparam int JNT_STG  = CORDIC_LAT + 1;
  localparam int NSTG     = CORDIC_LAT + 2 + 2 * JOINT_COUNT;
  localparam int OUT_STG  = NSTG - 1;
  localparam int RSH      = QBITS - FRAC_BITS;
  localparam logic signed [33:0] ROT_HI =
      (FRAC_BITS >= 17) ? 34'sd131071 : (34'sd1 <<< FRAC_BITS);
  localparam logic signed [33:0] ROT_LO =
      (FRAC_BITS >= 17) ? -34'sd131072 : -(34'sd1 <<< FRAC_BITS);

  // Geometry registers
  len_t d1_q, a2_q, a3_q, d4_q, d5_q, d6_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_q <= RST_D1;
      a2_q <= RST_A2;
      a3_q <= RST_A3;
      d4_q <= RST_D4;
      d5_q <= RST_D5;
      d6_q <= RST_D6;
    end else if (cfg_i.valid) begin
      case (dhfk_reg_e'(cfg_i.index))
        REG_D1:  d1_q <= $signed(cfg_i.data);
        REG_A2:  a2_q <= $signed(cfg_i.data);
        REG_A3:  a3_q <= $signed(cfg_i.data);
        REG_D4:  d4_q <= $signed(cfg_i.data);
        REG_D5:  d5_q <= $signed(cfg_i.data);
        REG_D6:  d6_q <= $signed(cfg_i.data);
        default: ;
      endcase
    end
  end

  len_t len_a [JOINT_COUNT];
  len_t len_d [JOINT_COUNT];

  always_comb begin
    for (int j = 0; j < JOINT_COUNT; j++) begin
      len_a[j] = '0;
      len_d[j] = '0;
    end
    len_d[0] = d1_q;
    len_a[1] = a2_q;
    len_a[2] = a3_q;
    len_d[3] = d4_q;
    len_d[4] = d5_q;
    len_d[5] = d6_q;
  end

  // Stage valid bits; a stage moves when it or any later stage is empty
  logic [NSTG-1:0] v_q;
  logic [NSTG-1:0] en;

  always_comb begin
    for (int k = 0; k < NSTG; k++) begin
      en[k] = out_o.ready | (|(~v_q & ({NSTG{1'b1}} << k)));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (en[k]) begin
          v_q[k] <= (k == 0) ? in_i.valid : v_q[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  assign in_i.ready = en[0];

  // Sine and cosine of all six joints in parallel
  logic [15:0] angle [JOINT_COUNT];
  trig_t       cj    [JOINT_COUNT];
  trig_t       sj    [JOINT_COUNT];

  assign angle[0] = in_i.angle_j1;
  assign angle[1] = in_i.angle_j2;
  assign angle[2] = in_i.angle_j3;
  assign angle[3] = in_i.angle_j4;
  assign angle[4] = in_i.angle_j5;
  assign angle[5] = in_i.angle_j6;

  for (genvar j = 0; j < JOINT_COUNT; j++) begin : g_cordic
    dhfk_cordic #(
      .ANGLE_BITS(ANGLE_BITS)
    ) u_cordic (
      .clk_i  (clk_i),
      .en_i   (en[CORDIC_LAT-1:0]),
      .angle_i(angle[j]),
      .cos_o  (cj[j]),
      .sin_o  (sj[j])
    );
  end

  // Local translations, then carry trig data along the chain
  dhfk_side_t         sd_q [SIDE_STG:NSTG-4];
  logic signed [49:0] ac   [JOINT_COUNT];
  logic signed [49:0] as   [JOINT_COUNT];

  always_comb begin
    for (int j = 0; j < JOINT_COUNT; j++) begin
      ac[j] = len_a[j] * cj[j] + (50'sd1 <<< (QBITS - 1));
      as[j] = len_a[j] * sj[j] + (50'sd1 <<< (QBITS - 1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[SIDE_STG]) begin
      for (int j = 0; j < JOINT_COUNT; j++) begin
        sd_q[SIDE_STG].c[j]  <= cj[j];
        sd_q[SIDE_STG].s[j]  <= sj[j];
        sd_q[SIDE_STG].t0[j] <= tloc_t'(ac[j] >>> QBITS);
        sd_q[SIDE_STG].t1[j] <= tloc_t'(as[j] >>> QBITS);
      end
    end
    for (int k = SIDE_STG + 1; k <= NSTG - 4; k++) begin
      if (en[k]) begin
        sd_q[k] <= sd_q[k-1];
      end
    end
  end

  // Chain of joint transforms starting from the identity
  rq_t  jr [JOINT_COUNT+1][3][3];
  pos_t jp [JOINT_COUNT+1][3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      jp[0][r] = '0;
      for (int c = 0; c < 3; c++) begin
        jr[0][r][c] = (r == c) ? ONE_Q : '0;
      end
    end
  end

  for (genvar j = 0; j < JOINT_COUNT; j++) begin : g_joint
    dhfk_joint u_joint (
      .clk_i  (clk_i),
      .en_i   (en[JNT_STG+2*j +: 2]),
      .twist_i(JOINT_TWIST[j]),
      .r_i    (jr[j]),
      .p_i    (jp[j]),
      .cos_i  (trig_t'(sd_q[SIDE_STG+2*j].c[j])),
      .sin_i  (trig_t'(sd_q[SIDE_STG+2*j].s[j])),
      .t0_i   (tloc_t'(sd_q[SIDE_STG+2*j].t0[j])),
      .t1_i   (tloc_t'(sd_q[SIDE_STG+2*j].t1[j])),
      .d_i    (len_d[j]),
      .r_o    (jr[j+1]),
      .p_o    (jp[j+1])
    );
  end

  // Round rotation to the output format, saturate everything
  logic signed [33:0] rw    [3][3];
  logic signed [17:0] rot_d [3][3];
  logic signed [19:0] pos_d [3];
  logic signed [17:0] rot_q [3][3];
  logic signed [19:0] pos_q [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        rw[r][c] = ($signed({jr[JOINT_COUNT][r][c][32], jr[JOINT_COUNT][r][c]})
                    + (34'sd1 <<< (RSH - 1))) >>> RSH;
        if (rw[r][c] > ROT_HI) begin
          rot_d[r][c] = ROT_HI[17:0];
        end else if (rw[r][c] < ROT_LO) begin
          rot_d[r][c] = ROT_LO[17:0];
        end else begin
          rot_d[r][c] = rw[r][c][17:0];
        end
      end
      if (jp[JOINT_COUNT][r] > 24'sd524287) begin
        pos_d[r] = 20'sd524287;
      end else if (jp[JOINT_COUNT][r] < -24'sd524288) begin
        pos_d[r] = -20'sd524288;
      end else begin
        pos_d[r] = jp[JOINT_COUNT][r][19:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[OUT_STG]) begin
      rot_q <= rot_d;
      pos_q <= pos_d;
    end
  end

  assign out_o.valid  = v_q[OUT_STG];
  assign out_o.rot_00 = rot_q[0][0];
  assign out_o.rot_01 = rot_q[0][1];
  assign out_o.rot_02 = rot_q[0][2];
  assign out_o.rot_10 = rot_q[1][0];
  assign out_o.rot_11 = rot_q[1][1];
  assign out_o.rot_12 = rot_q[1][2];
  assign out_o.rot_20 = rot_q[2][0];
  assign out_o.rot_21 = rot_q[2][1];
  assign out_o.rot_22 = rot_q[2][2];
  assign out_o.pos_x  = pos_q[0];
  assign out_o.pos_y  = pos_q[1];
  assign out_o.pos_z  = pos_q[2];

`ifndef SYNTHESIS
  // An accepted word lands in the first stage
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (in_i.valid && in_i.ready) |=> v_q[0])
    else $error("accepted word did not enter the pipeline");

  // A pose appears only when the last joint stage held one
  a_out_from_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
      $rose(v_q[OUT_STG]) |-> $past(v_q[OUT_STG-1]))
    else $error("output valid without a word in the last joint stage");

  // Rotation entries [0][0] and [2][2] stay within unit range
  a_rot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
      v_q[OUT_STG] |-> (rot_q[0][0] <= ROT_HI && rot_q[0][0] >= ROT_LO &&
                        rot_q[2][2] <= ROT_HI && rot_q[2][2] >= ROT_LO))
    else $error("rotation entry out of range");
`endif

endmodule
